>>> hdl/bsfr_pkg.sv
// shared types and constants for the byte stuffed frame receiver
`default_nettype none

package bsfr_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 1024;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned CNT32_W = 32;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned M_DATA_W = 88;
    localparam int unsigned M_USER_W = 2;

    localparam logic [BYTE_W-1:0] SYNC_CHAR_RST    = 8'd126;
    localparam logic [BYTE_W-1:0] ESC_CHAR_RST     = 8'd125;
    localparam logic [BYTE_W-1:0] ESC_SYNC_RST     = 8'd94;
    localparam logic [BYTE_W-1:0] ESC_ESC_RST      = 8'd93;

    typedef enum logic [IDX_W-1:0] {
        CFG_SYNC_CHAR = 2'd0,
        CFG_ESC_CHAR  = 2'd1,
        CFG_ESC_SYNC  = 2'd2,
        CFG_ESC_ESC   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [CNT32_W-1:0] out_of_frame_bytes;
        logic [CNT32_W-1:0] frames_received;
        logic               frame_overflow;
        logic [LEN_W-1:0]   frame_length;
        logic               frame_end;
        logic [BYTE_W-1:0]  payload_byte;
        logic               byte_present;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/byte_stuffed_frame_receiver_core.sv
// byte stuffed frame receiver: deframer state, counters and output skid stage
//
// channel   dir  handshake          payload
// s_axis    in   tvalid / tready    tdata: rx_byte
// m_axis    out  tvalid / tready    tdata, tuser, tlast (see port list)
// cfg       in   i_cfg_wr_en        i_cfg_index, i_cfg_wr_data
//
// one byte per clock while s_axis_tready is high; the decode and the counter
// updates sit between the state registers and the result register
// the result register plus one skid entry let the input keep flowing while
// the output is stalled; s_axis_tready drops only when both are full
// synchronous active-low reset restores the default codes and clears state
`default_nettype none

module byte_stuffed_frame_receiver_core #(
    parameter int unsigned MAX_FRAME_BYTES = bsfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // rx_byte [7:0]
    input  wire logic [bsfr_pkg::BYTE_W-1:0]    s_axis_tdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // payload_byte [7:0], frame_length [18:8], frames_received [50:19],
    // out_of_frame_bytes [82:51], zero [87:83]
    output logic [bsfr_pkg::M_DATA_W-1:0]       m_axis_tdata,
    // byte_present [0], frame_overflow [1]
    output logic [bsfr_pkg::M_USER_W-1:0]       m_axis_tuser,
    // frame_end
    output logic                                m_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bsfr_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]    i_cfg_wr_data
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned EXT_W = (CNT_W > bsfr_pkg::LEN_W) ? CNT_W : bsfr_pkg::LEN_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

    logic [bsfr_pkg::BYTE_W-1:0]  r_sync_char;
    logic [bsfr_pkg::BYTE_W-1:0]  r_esc_char;
    logic [bsfr_pkg::BYTE_W-1:0]  r_esc_sync;
    logic [bsfr_pkg::BYTE_W-1:0]  r_esc_esc;

    logic                         r_in_frame, n_in_frame;
    logic                         r_escape_pending, n_escape_pending;
    logic [CNT_W-1:0]             r_byte_count, n_byte_count;
    logic                         r_overflow_seen, n_overflow_seen;
    logic [bsfr_pkg::CNT32_W-1:0] r_frame_counter, n_frame_counter;
    logic [bsfr_pkg::CNT32_W-1:0] r_stray_counter, n_stray_counter;

    bsfr_pkg::t_result            n_result;
    bsfr_pkg::t_result            r_out;
    bsfr_pkg::t_result            r_skid;
    logic                         r_out_valid;
    logic                         r_skid_valid;

    logic                         s_accept;
    logic [bsfr_pkg::BYTE_W-1:0]  rx;
    logic                         present;
    logic                         ended;
    logic [bsfr_pkg::BYTE_W-1:0]  data;
    logic [EXT_W-1:0]             len_ext;

    assign s_axis_tready = !r_skid_valid;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_char <= bsfr_pkg::SYNC_CHAR_RST;
            r_esc_char  <= bsfr_pkg::ESC_CHAR_RST;
            r_esc_sync  <= bsfr_pkg::ESC_SYNC_RST;
            r_esc_esc   <= bsfr_pkg::ESC_ESC_RST;
        end else if (i_cfg_wr_en) begin
            unique case (bsfr_pkg::t_cfg_reg'(i_cfg_index))
                bsfr_pkg::CFG_SYNC_CHAR: r_sync_char <= i_cfg_wr_data;
                bsfr_pkg::CFG_ESC_CHAR:  r_esc_char  <= i_cfg_wr_data;
                bsfr_pkg::CFG_ESC_SYNC:  r_esc_sync  <= i_cfg_wr_data;
                bsfr_pkg::CFG_ESC_ESC:   r_esc_esc   <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // per-byte decode
    always_comb begin
        n_in_frame       = r_in_frame;
        n_escape_pending = r_escape_pending;
        n_byte_count     = r_byte_count;
        n_overflow_seen  = r_overflow_seen;
        n_frame_counter  = r_frame_counter;
        n_stray_counter  = r_stray_counter;
        present          = 1'b0;
        ended            = 1'b0;
        data             = '0;
        len_ext          = '0;

        if (!r_in_frame) begin
            if (rx == r_sync_char) begin
                n_in_frame = 1'b1;
            end else begin
                n_stray_counter = r_stray_counter + 1'b1;
            end
        end else if (r_escape_pending) begin
            n_escape_pending = 1'b0;
            if (rx == r_esc_sync) begin
                data = r_sync_char;
            end else if (rx == r_esc_esc) begin
                data = r_esc_char;
            end else begin
                data  = r_sync_char;
                ended = 1'b1;
            end
            if (r_byte_count >= MAX_CNT) begin
                n_overflow_seen = 1'b1;
            end else begin
                n_byte_count = r_byte_count + 1'b1;
                present      = 1'b1;
            end
        end else if (rx == r_esc_char) begin
            n_escape_pending = 1'b1;
        end else if (rx == r_sync_char) begin
            ended = (r_byte_count != '0);
        end else begin
            data = rx;
            if (r_byte_count >= MAX_CNT) begin
                n_overflow_seen = 1'b1;
            end else begin
                n_byte_count = r_byte_count + 1'b1;
                present      = 1'b1;
            end
        end

        len_ext = EXT_W'(n_byte_count);

        n_result.byte_present       = present;
        n_result.payload_byte       = present ? data : '0;
        n_result.frame_end          = ended;
        n_result.frame_length       = len_ext[bsfr_pkg::LEN_W-1:0];
        n_result.frame_overflow     = n_overflow_seen;

        if (ended) begin
            n_frame_counter  = r_frame_counter + 1'b1;
            n_byte_count     = '0;
            n_overflow_seen  = 1'b0;
            n_escape_pending = 1'b0;
            n_in_frame       = 1'b0;
        end

        n_result.frames_received    = n_frame_counter;
        n_result.out_of_frame_bytes = n_stray_counter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame       <= 1'b0;
            r_escape_pending <= 1'b0;
            r_byte_count     <= '0;
            r_overflow_seen  <= 1'b0;
            r_frame_counter  <= '0;
            r_stray_counter  <= '0;
        end else if (s_accept) begin
            r_in_frame       <= n_in_frame;
            r_escape_pending <= n_escape_pending;
            r_byte_count     <= n_byte_count;
            r_overflow_seen  <= n_overflow_seen;
            r_frame_counter  <= n_frame_counter;
            r_stray_counter  <= n_stray_counter;
        end
    end

    // result register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (m_axis_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= s_accept;
            end
        end else if (s_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_axis_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (s_accept) begin
                r_out <= n_result;
            end
        end else if (s_accept) begin
            r_skid <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.frame_end;
    assign m_axis_tuser  = {r_out.frame_overflow, r_out.byte_present};
    assign m_axis_tdata  = {5'd0, r_out.out_of_frame_bytes, r_out.frames_received,
                            r_out.frame_length, r_out.payload_byte};

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while result register empty");

    a_escape_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_escape_pending |-> r_in_frame)
        else $error("escape pending outside a frame");

    a_overflow_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow_seen |-> (r_byte_count == MAX_CNT))
        else $error("overflow flagged below the maximum length");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= MAX_CNT)
        else $error("byte count beyond the maximum length");

    a_frame_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && ended) |=> (r_frame_counter == $past(r_frame_counter) + 1'b1)
                                && !r_in_frame && (r_byte_count == '0))
        else $error("frame end did not close the frame");

endmodule

`default_nettype wire

>>> tb/tb_byte_stuffed_frame_receiver_core.sv
// testbench for the byte stuffed frame receiver core with a deframer predictor
`default_nettype none

module tb_byte_stuffed_frame_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_BYTES = bsfr_pkg::MAX_FRAME_BYTES_DEF;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned RANDOM_PER_PHASE = 190;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic [bsfr_pkg::BYTE_W-1:0]     s_axis_tdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [bsfr_pkg::M_DATA_W-1:0]   m_axis_tdata;
    logic [bsfr_pkg::M_USER_W-1:0]   m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic                            i_cfg_wr_en = 1'b0;
    logic [bsfr_pkg::IDX_W-1:0]      i_cfg_index = '0;
    logic [bsfr_pkg::BYTE_W-1:0]     i_cfg_wr_data = '0;

    // predictor copy of the codes and the deframer state
    logic [7:0]  cfg_sync;
    logic [7:0]  cfg_esc;
    logic [7:0]  cfg_esc_sync;
    logic [7:0]  cfg_esc_esc;
    logic        rx_in_frame;
    logic        rx_esc_armed;
    int unsigned rx_stored;
    logic        rx_dropped;
    logic [31:0] frames_done;
    logic [31:0] stray_bytes;

    bsfr_pkg::t_result decoded_queue[$];
    int unsigned fail_count = 0;
    int unsigned sent_items = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        holding = 1'b0;
    event        hold_start;

    byte_stuffed_frame_receiver_core #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    // payload store with the length limit
    function automatic logic take_byte();
        if (rx_stored >= MAX_BYTES) begin
            rx_dropped = 1'b1;
            return 1'b0;
        end
        rx_stored++;
        return 1'b1;
    endfunction

    function automatic bsfr_pkg::t_result deframe_byte(input logic [7:0] b);
        bsfr_pkg::t_result r;
        logic              ended;
        logic [7:0]        dec;
        r = '0;
        ended = 1'b0;
        dec = '0;
        if (!rx_in_frame) begin
            if (b == cfg_sync) rx_in_frame = 1'b1;
            else stray_bytes++;
        end else if (rx_esc_armed) begin
            rx_esc_armed = 1'b0;
            if (b == cfg_esc_sync) begin
                dec = cfg_sync;
            end else if (b == cfg_esc_esc) begin
                dec = cfg_esc;
            end else begin
                dec = cfg_sync;
                ended = 1'b1;
            end
            r.byte_present = take_byte();
        end else if (b == cfg_esc) begin
            rx_esc_armed = 1'b1;
        end else if (b == cfg_sync) begin
            if (rx_stored != 0) ended = 1'b1;
        end else begin
            dec = b;
            r.byte_present = take_byte();
        end
        if (r.byte_present) r.payload_byte = dec;
        r.frame_length = rx_stored[bsfr_pkg::LEN_W-1:0];
        r.frame_overflow = rx_dropped;
        if (ended) begin
            frames_done++;
            rx_stored = 0;
            rx_dropped = 1'b0;
            rx_esc_armed = 1'b0;
            rx_in_frame = 1'b0;
        end
        r.frame_end = ended;
        r.frames_received = frames_done;
        r.out_of_frame_bytes = stray_bytes;
        return r;
    endfunction

    // input side monitor: predictor update on each accepted byte and code write
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_sync = bsfr_pkg::SYNC_CHAR_RST;
            cfg_esc = bsfr_pkg::ESC_CHAR_RST;
            cfg_esc_sync = bsfr_pkg::ESC_SYNC_RST;
            cfg_esc_esc = bsfr_pkg::ESC_ESC_RST;
            rx_in_frame = 1'b0;
            rx_esc_armed = 1'b0;
            rx_stored = 0;
            rx_dropped = 1'b0;
            frames_done = '0;
            stray_bytes = '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (bsfr_pkg::t_cfg_reg'(i_cfg_index))
                    bsfr_pkg::CFG_SYNC_CHAR: cfg_sync = i_cfg_wr_data;
                    bsfr_pkg::CFG_ESC_CHAR:  cfg_esc = i_cfg_wr_data;
                    bsfr_pkg::CFG_ESC_SYNC:  cfg_esc_sync = i_cfg_wr_data;
                    bsfr_pkg::CFG_ESC_ESC:   cfg_esc_esc = i_cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                decoded_queue.push_back(deframe_byte(s_axis_tdata));
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // output side checker
    always @(posedge i_clk) begin
        bsfr_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_queue.size() == 0) begin
                $error("result transaction with no expectation pending");
                fail_count++;
            end else begin
                want = decoded_queue.pop_front();
                check_field("byte_present", want.byte_present, m_axis_tuser[0]);
                check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
                check_field("frame_end", want.frame_end, m_axis_tlast);
                check_field("frame_length", want.frame_length, m_axis_tdata[18:8]);
                check_field("frame_overflow", want.frame_overflow, m_axis_tuser[1]);
                check_field("frames_received", want.frames_received,
                            m_axis_tdata[50:19]);
                check_field("out_of_frame_bytes", want.out_of_frame_bytes,
                            m_axis_tdata[82:51]);
                check_field("tdata_pad", '0, m_axis_tdata[87:83]);
            end
        end
    end

    // receiver stalls, random or held off for a long stretch
    always @(posedge i_clk) begin
        m_axis_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        forever begin
            @(hold_start);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (decoded_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_codes(input logic [7:0] sync_v, input logic [7:0] esc_v,
                               input logic [7:0] esc_sync_v, input logic [7:0] esc_esc_v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= bsfr_pkg::CFG_SYNC_CHAR;
        i_cfg_wr_data <= sync_v;
        @(posedge i_clk);
        i_cfg_index <= bsfr_pkg::CFG_ESC_CHAR;
        i_cfg_wr_data <= esc_v;
        @(posedge i_clk);
        i_cfg_index <= bsfr_pkg::CFG_ESC_SYNC;
        i_cfg_wr_data <= esc_sync_v;
        @(posedge i_clk);
        i_cfg_index <= bsfr_pkg::CFG_ESC_ESC;
        i_cfg_wr_data <= esc_esc_v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_code();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // biased toward the current special characters
    function automatic logic [7:0] pick_rx_byte();
        case ($urandom_range(15))
            0: return cfg_sync;
            1: return cfg_esc;
            2: return cfg_esc_sync;
            3: return cfg_esc_esc;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_burst();
        int unsigned n;
        logic [7:0]  b;
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(0, 2)) send_byte(pick_rx_byte());
        send_byte(cfg_sync);
        if ($urandom_range(99) < 15) send_byte(cfg_sync);
        n = $urandom_range(0, 14);
        repeat (n) begin
            b = pick_rx_byte();
            if ($urandom_range(99) < 4) begin
                // escape with an arbitrary code, often unknown
                send_byte(cfg_esc);
                send_byte(8'($urandom_range(255)));
            end else if (b == cfg_sync || b == cfg_esc) begin
                send_byte(cfg_esc);
                send_byte(b == cfg_sync ? cfg_esc_sync : cfg_esc_esc);
            end else begin
                send_byte(b);
            end
        end
        send_byte(cfg_sync);
    endtask

    task automatic test_default_codes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(bsfr_pkg::SYNC_CHAR_RST);
        send_byte(bsfr_pkg::SYNC_CHAR_RST);     // empty frame sync
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(bsfr_pkg::ESC_CHAR_RST);
        send_byte(bsfr_pkg::ESC_SYNC_RST);
        send_byte(bsfr_pkg::ESC_CHAR_RST);
        send_byte(bsfr_pkg::ESC_ESC_RST);
        send_byte(bsfr_pkg::SYNC_CHAR_RST);
        send_byte(bsfr_pkg::SYNC_CHAR_RST);
        send_byte(8'h41);
        send_byte(bsfr_pkg::ESC_CHAR_RST);
        send_byte(8'h33);                       // unknown escape code ends the frame
        send_byte(8'h12);
        drain();
    endtask

    task automatic test_extreme_codes();
        write_codes(8'h00, 8'hFF, 8'h80, 8'h80);    // equal escape codes
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h00);
        drain();
        write_codes(8'hFF, 8'h00, 8'h01, 8'hFE);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFE);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'hFF);
        drain();
    endtask

    task automatic test_length_limit();
        write_codes(bsfr_pkg::SYNC_CHAR_RST, bsfr_pkg::ESC_CHAR_RST,
                    bsfr_pkg::ESC_SYNC_RST, bsfr_pkg::ESC_ESC_RST);
        send_byte(cfg_sync);
        repeat (MAX_BYTES + 3) send_byte(8'h55);
        send_byte(cfg_esc);
        send_byte(8'h00);               // sync stored past the limit is dropped
        send_byte(cfg_sync);
        repeat (4) send_byte(8'hA5);
        send_byte(cfg_sync);
        drain();
    endtask

    task automatic test_backpressure();
        -> hold_start;
        send_byte(cfg_sync);
        repeat (24) send_byte(8'($urandom_range(255)));
        send_byte(cfg_sync);
        drain();
    endtask

    task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct);
        int unsigned stop_at;
        write_codes(rand_code(), rand_code(), rand_code(), rand_code());
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        stop_at = sent_items + RANDOM_PER_PHASE;
        while (sent_items < stop_at) send_random_burst();
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 11;
        recv_stall_pct = 71;
        test_default_codes();
        test_extreme_codes();
        test_length_limit();
        test_backpressure();
        test_random(11, 71);
        test_random(71, 11);
        test_random(0, 0);
        if (decoded_queue.size() != 0) begin
            $error("%0d expected results never arrived", decoded_queue.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hdl/bsfr_pkg.sv
hdl/byte_stuffed_frame_receiver_core.sv
tb/tb_byte_stuffed_frame_receiver_core.sv
